// ===== rtl/core/pitr_pkg.sv =====
`timescale 1ns / 1ps

package pitr_pkg;

  // subnet counts fixed by the field widths
  localparam int unsigned NetSubnets = 4;
  localparam int unsigned CsSubnets  = 2;

  // bus access codes
  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActWrite = 2'd2;

  // register map
  localparam logic [3:0] RegMask    = 4'd0;
  localparam logic [3:0] RegStatus  = 4'd1;
  localparam logic [3:0] RegSlice   = 4'd2;
  localparam logic [3:0] RegAddress = 4'd3;
  localparam logic [3:0] RegTicks   = 4'd4;
  localparam logic [3:0] RegSend    = 4'd5;
  localparam logic [3:0] RegRecv    = 4'd6;
  localparam logic [3:0] RegReqs    = 4'd7;
  localparam logic [3:0] RegPending = 4'd8;
  localparam logic [3:0] RegSlack   = 4'd9;
  localparam logic [3:0] RegHandle  = 4'd10;
  localparam logic [3:0] RegReqOut  = 4'd11;
  localparam logic [3:0] RegEnd     = 4'd12;
  localparam logic [3:0] RegHold    = 4'd13;

  // one tick of bus access and side inputs
  typedef struct packed {
    logic [1:0]           action;
    logic [3:0]           reg_select;
    logic [31:0]          write_data;
    logic [NetSubnets-1:0] network_interrupts;
    logic [CsSubnets-1:0]  cs_request_in;
    logic                 send_active;
    logic                 receive_active;
  } pitr_item_t;

  // one tick of results
  typedef struct packed {
    logic [31:0]          read_data;
    logic                 interrupt;
    logic [7:0]           interrupt_status;
    logic [CsSubnets-1:0] cs_request_out;
    logic                 end_of_run;
    logic                 clock_running;
  } pitr_result_t;

endpackage

// ===== rtl/core/pitr_apb.sv =====
`timescale 1ns / 1ps

module pitr_apb import pitr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] node_address_o
);

  logic [15:0] node_address_q;
  logic        wr_en;

  assign pready = 1'b1;

  // access phase of a write to the address register
  assign wr_en = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= '0;
    end else if (wr_en) begin
      node_address_q <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'b0) begin
      prdata = {16'd0, node_address_q};
    end
  end

  assign node_address_o = node_address_q;

endmodule

// ===== rtl/core/pitr_regs.sv =====
`timescale 1ns / 1ps

module pitr_regs import pitr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  pitr_item_t   item_i,
  input  logic [15:0]  node_address_i,
  output pitr_result_t result_o
);

  logic [31:0]          irq_mask_q, irq_mask_d;
  logic [31:0]          slice_q, slice_d;
  logic [31:0]          slack_q, slack_d;
  logic                 pending_q, pending_d;
  logic [CsSubnets-1:0] req_q, req_d;
  logic [31:0]          ticks_q, ticks_d;
  logic                 clk_en_q, clk_en_d;

  logic                 rd, wr;
  logic [7:0]           status;
  logic                 irq;
  logic [31:0]          rdata;
  logic [CsSubnets-1:0] handle;
  logic [CsSubnets-1:0] reqout;

  assign rd = (item_i.action == ActRead);
  assign wr = (item_i.action == ActWrite);

  // interrupt status from state before the tick
  always_comb begin
    status = '0;
    status[7:4] = item_i.network_interrupts;
    status[3]   = |req_q;
    status[2]   = !item_i.send_active && (slack_q == 32'd1);
    status[1]   = !item_i.send_active && pending_q;
    status[0]   = (slice_q == 32'd1);
  end

  assign irq = |(status & irq_mask_q[7:0]);

  // read mux
  always_comb begin
    rdata = '0;
    if (rd) begin
      case (item_i.reg_select)
        RegMask:    rdata = irq_mask_q;
        RegStatus:  rdata = {24'd0, status};
        RegSlice:   rdata = slice_q;
        RegAddress: rdata = {16'd0, node_address_i};
        RegTicks:   rdata = ticks_q;
        RegSend:    rdata = {31'd0, item_i.send_active};
        RegRecv:    rdata = {31'd0, item_i.receive_active};
        RegReqs:    rdata = {{(32-CsSubnets){1'b0}}, req_q};
        default:    rdata = '0;
      endcase
    end
  end

  assign handle = (wr && item_i.reg_select == RegHandle) ?
                  item_i.write_data[CsSubnets-1:0] : '0;
  assign reqout = (wr && item_i.reg_select == RegReqOut) ?
                  item_i.write_data[CsSubnets-1:0] : '0;

  // next state
  always_comb begin
    req_d = item_i.cs_request_in | (req_q & ~handle);

    irq_mask_d = irq_mask_q;
    if (wr && item_i.reg_select == RegMask) irq_mask_d = item_i.write_data;

    slice_d = slice_q;
    if (wr && item_i.reg_select == RegSlice) begin
      slice_d = item_i.write_data;
    end else if (slice_q > 32'd1) begin
      slice_d = slice_q - 32'd1;
    end

    pending_d = pending_q;
    if (wr && item_i.reg_select == RegPending) pending_d = |item_i.write_data;

    slack_d = slack_q;
    if (wr && item_i.reg_select == RegSlack) begin
      slack_d = item_i.write_data;
    end else if (slack_q > 32'd1) begin
      slack_d = slack_q - 32'd1;
    end

    ticks_d = ticks_q + 32'd1;

    clk_en_d = clk_en_q;
    if (wr && item_i.reg_select == RegHold) begin
      clk_en_d = 1'b0;
    end else if (irq) begin
      clk_en_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_mask_q <= '0;
      slice_q    <= '0;
      slack_q    <= '0;
      pending_q  <= 1'b0;
      req_q      <= '0;
      ticks_q    <= '0;
      clk_en_q   <= 1'b1;
    end else if (step_i) begin
      irq_mask_q <= irq_mask_d;
      slice_q    <= slice_d;
      slack_q    <= slack_d;
      pending_q  <= pending_d;
      req_q      <= req_d;
      ticks_q    <= ticks_d;
      clk_en_q   <= clk_en_d;
    end
  end

  // results of this tick
  always_comb begin
    result_o.read_data        = rdata;
    result_o.interrupt        = irq;
    result_o.interrupt_status = status;
    result_o.cs_request_out   = reqout;
    result_o.end_of_run       = wr && (item_i.reg_select == RegEnd);
    result_o.clock_running    = clk_en_d;
  end

endmodule

// ===== rtl/core/pe_interrupt_timer_registers_unit.sv =====
`timescale 1ns / 1ps

// Register block of a processing element: interrupt mask, time-slice and
// slack countdowns, pending flag, circuit-switch requests, tick counter and
// clock gate.
// Input channel (in_valid_i / in_stall_o) carries one tick: an optional bus
// read or write plus the network interrupt, request and busy lines.
// Output channel (out_valid_o / out_stall_i) returns one result per tick:
// read data, interrupt, status word, request pulses, end flag, clock gate.
// An accepted transfer lands in an input register; the register logic then
// forms the result from it, and at the edge where it updates its state the
// result register loads that result; both wait while the output register is
// full and stalled. One transfer per cycle is sustained while the receiver
// does not stall; the single state update per item in the register logic
// sets that rate.
// When the receiver stalls, the result holds in the output register and the
// input register keeps its item; the input stalls only once both are full.
// Reset clears all countdowns, mask, flags and counter, sets the clock gate
// to running and empties both registers. The user writes the node address
// over the APB port only while the block is idle; it does not enforce this.

module pe_interrupt_timer_registers_unit import pitr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [3:0]            reg_select_i,
  input  logic [31:0]           write_data_i,
  input  logic [NetSubnets-1:0] network_interrupts_i,
  input  logic [CsSubnets-1:0]  cs_request_in_i,
  input  logic                  send_active_i,
  input  logic                  receive_active_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           read_data_o,
  output logic                  interrupt_o,
  output logic [7:0]            interrupt_status_o,
  output logic [CsSubnets-1:0]  cs_request_out_o,
  output logic                  end_of_run_o,
  output logic                  clock_running_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic         in_valid_q;
  pitr_item_t   item_q;
  logic         out_valid_q;
  pitr_result_t result_q;
  pitr_result_t result;
  logic         out_free;
  logic         step;
  logic         in_take;
  logic [15:0]  node_address;

  // output register free this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action             <= action_i;
      item_q.reg_select         <= reg_select_i;
      item_q.write_data         <= write_data_i;
      item_q.network_interrupts <= network_interrupts_i;
      item_q.cs_request_in      <= cs_request_in_i;
      item_q.send_active        <= send_active_i;
      item_q.receive_active     <= receive_active_i;
    end
  end

  pitr_apb u_apb (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .node_address_o (node_address)
  );

  pitr_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (item_q),
    .node_address_i (node_address),
    .result_o       (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = result_q.read_data;
  assign interrupt_o        = result_q.interrupt;
  assign interrupt_status_o = result_q.interrupt_status;
  assign cs_request_out_o   = result_q.cs_request_out;
  assign end_of_run_o       = result_q.end_of_run;
  assign clock_running_o    = result_q.clock_running;

`ifndef SYNTHESIS
  // a processed item shows up as a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni) step |=> out_valid_q)
    else $error("processed item did not reach output register");

  // a stalled full output with a waiting item must stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while both registers are full");

  // empty pipeline never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");
`endif

endmodule
